// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/dltq_pkg.sv =====
// shared constants and types of the delta list timeout queue
package dltq_pkg;

    localparam int POOL_SIZE   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(POOL_SIZE);
    localparam int LINK_W      = $clog2(POOL_SIZE + 1);
    localparam int BUF_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_SIZE);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_RESULTS);

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_CANCEL  = 2'd1;
    localparam logic [1:0] MODE_ADVANCE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_POOL_FULL = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       alloc;
        logic       walk_step;
        logic       ins_place;
        logic       ins_link;
        logic       can_step;
        logic       can_unlink;
        logic       can_sum;
        logic       adv_sub;
        logic       adv_pop;
        logic       ptr_head;
        logic       emit;
        logic       emit_next;
        logic       code_we;
        logic [2:0] code;
    } dltq_cmd_t;

    // flags from datapath to controller
    typedef struct packed {
        logic free_found;
        logic ptr_nil;
        logic delta_gt;
        logic match;
        logic delta_zero;
        logic n_full;
        logic head_nil;
        logic emit_last;
    } dltq_stat_t;

endpackage

// ===== rtl/dltq_datapath.sv =====
// entry pool, walk pointers, result buffer and result ports
`include "assert_macros.svh"

module dltq_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  dltq_pkg::dltq_cmd_t cmd,
    output dltq_pkg::dltq_stat_t stat,
    input  logic [31:0]         delay_ms,
    input  logic [7:0]          handler_id,
    input  logic [15:0]         arg_id,
    input  logic [31:0]         elapsed_ms,
    output logic                strobe,
    output logic [2:0]          status,
    output logic [7:0]          expired_handler,
    output logic [15:0]         expired_arg,
    output logic [31:0]         head_remaining,
    output logic                last
);
    import dltq_pkg::*;

    logic [31:0]       delta_reg   [POOL_SIZE];
    logic [7:0]        handler_reg [POOL_SIZE];
    logic [15:0]       arg_reg     [POOL_SIZE];
    logic [LINK_W-1:0] link_reg    [POOL_SIZE];
    logic [POOL_SIZE-1:0] used_reg;
    logic [LINK_W-1:0] head_reg;

    logic [23:0]       buf_reg [MAX_RESULTS];

    logic [LINK_W-1:0] ptr_reg, t_reg, slot_reg;
    logic [31:0]       d_reg, elapsed_reg, cd_reg;
    logic [7:0]        h_reg;
    logic [15:0]       a_reg;
    logic [CNT_W-1:0]  n_reg, e_reg;
    logic [2:0]        code_reg;

    logic [SLOT_W-1:0] ptr_idx, slot_idx, t_idx;
    logic [31:0]       rd_delta;
    logic [7:0]        rd_handler;
    logic [15:0]       rd_arg;
    logic [LINK_W-1:0] rd_link;
    logic [LINK_W-1:0] free_slot;
    logic              free_found;
    logic [32:0]       sum_wide;
    logic [31:0]       sum_sat, sub_sat;
    logic [23:0]       buf_rd;

    assign ptr_idx  = ptr_reg[SLOT_W-1:0];
    assign slot_idx = slot_reg[SLOT_W-1:0];
    assign t_idx    = t_reg[SLOT_W-1:0];

    // single read port at the walk pointer
    assign rd_delta   = delta_reg[ptr_idx];
    assign rd_handler = handler_reg[ptr_idx];
    assign rd_arg     = arg_reg[ptr_idx];
    assign rd_link    = link_reg[ptr_idx];

    // lowest free slot
    always_comb
    begin
        free_slot  = NIL_LINK;
        free_found = 1'b0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot  = LINK_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // saturating delta arithmetic
    assign sum_wide = {1'b0, rd_delta} + {1'b0, cd_reg};
    assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    assign sub_sat  = (elapsed_reg < rd_delta) ? (rd_delta - elapsed_reg) : 32'd0;

    // status flags
    always_comb
    begin
        stat.free_found = free_found;
        stat.ptr_nil    = (ptr_reg == NIL_LINK);
        stat.delta_gt   = (rd_delta > d_reg);
        stat.match      = (rd_handler == h_reg) && (rd_arg == a_reg);
        stat.delta_zero = (rd_delta == 32'd0);
        stat.n_full     = (n_reg == MAX_CNT);
        stat.head_nil   = (head_reg == NIL_LINK);
        stat.emit_last  = (n_reg == '0) || (e_reg == n_reg - CNT_W'(1));
    end

    // entry pool payload
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            handler_reg[free_slot[SLOT_W-1:0]] <= h_reg;
            arg_reg[free_slot[SLOT_W-1:0]]     <= a_reg;
        end
        if (cmd.ins_place && (ptr_reg != NIL_LINK))
            delta_reg[ptr_idx] <= rd_delta - d_reg;
        else if (cmd.ins_link)
            delta_reg[slot_idx] <= d_reg;
        else if (cmd.can_sum && (ptr_reg != NIL_LINK))
            delta_reg[ptr_idx] <= sum_sat;
        else if (cmd.adv_sub)
            delta_reg[ptr_idx] <= sub_sat;
        if (cmd.ins_place)
            link_reg[slot_idx] <= ptr_reg;
        else if (cmd.ins_link && (t_reg != NIL_LINK))
            link_reg[t_idx] <= slot_reg;
        else if (cmd.can_unlink && (t_reg != NIL_LINK))
            link_reg[t_idx] <= rd_link;
        if (cmd.adv_pop)
            buf_reg[n_reg[BUF_W-1:0]] <= {rd_handler, rd_arg};
    end

    // used bits and head pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            head_reg <= NIL_LINK;
        end
        else
        begin
            if (cmd.alloc)
                used_reg[free_slot[SLOT_W-1:0]] <= 1'b1;
            else if (cmd.can_unlink || cmd.adv_pop)
                used_reg[ptr_idx] <= 1'b0;
            if (cmd.ins_link && (t_reg == NIL_LINK))
                head_reg <= slot_reg;
            else if (cmd.can_unlink && (t_reg == NIL_LINK))
                head_reg <= rd_link;
            else if (cmd.adv_pop)
                head_reg <= rd_link;
        end
    end

    // transaction registers and walk pointers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg       <= delay_ms;
            h_reg       <= handler_id;
            a_reg       <= arg_id;
            elapsed_reg <= elapsed_ms;
            t_reg       <= NIL_LINK;
            ptr_reg     <= head_reg;
            n_reg       <= '0;
        end
        if (cmd.alloc)
            slot_reg <= free_slot;
        if (cmd.walk_step)
        begin
            d_reg   <= d_reg - rd_delta;
            t_reg   <= ptr_reg;
            ptr_reg <= rd_link;
        end
        if (cmd.can_step)
        begin
            t_reg   <= ptr_reg;
            ptr_reg <= rd_link;
        end
        if (cmd.can_unlink)
        begin
            cd_reg  <= rd_delta;
            ptr_reg <= rd_link;
        end
        if (cmd.adv_pop)
        begin
            n_reg   <= n_reg + CNT_W'(1);
            ptr_reg <= rd_link;
        end
        if (cmd.ptr_head)
        begin
            ptr_reg <= head_reg;
            e_reg   <= '0;
        end
        if (cmd.emit_next)
            e_reg <= e_reg + CNT_W'(1);
        if (cmd.code_we)
            code_reg <= cmd.code;
    end

    // result ports
    assign buf_rd          = buf_reg[e_reg[BUF_W-1:0]];
    assign strobe          = cmd.emit;
    assign status          = (n_reg != '0) ? ST_EXPIRED : code_reg;
    assign expired_handler = (n_reg != '0) ? buf_rd[23:16] : 8'd0;
    assign expired_arg     = (n_reg != '0) ? buf_rd[15:0] : 16'd0;
    assign head_remaining  = (ptr_reg == NIL_LINK) ? 32'd0 : rd_delta;
    assign last            = stat.emit_last;

    `ASSERT_IMPLIES(a_head_used, clk, rst_n, head_reg != NIL_LINK, used_reg[head_reg[SLOT_W-1:0]])
    `ASSERT_IMPLIES(a_pop_bound, clk, rst_n, cmd.adv_pop, n_reg != MAX_CNT)
    `ASSERT_NEXT(a_last_ends, clk, rst_n, strobe && last, !strobe)
endmodule

// ===== rtl/dltq_ctrl.sv =====
// sequencing state machine of the delta list timeout queue
`include "assert_macros.svh"

module dltq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           mode,
    input  dltq_pkg::dltq_stat_t stat,
    output dltq_pkg::dltq_cmd_t  cmd,
    output logic                 busy
);
    import dltq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ALLOC    = 4'd1;
    localparam logic [3:0] S_INS_WALK = 4'd2;
    localparam logic [3:0] S_INS_LINK = 4'd3;
    localparam logic [3:0] S_CAN_WALK = 4'd4;
    localparam logic [3:0] S_CAN_SUM  = 4'd5;
    localparam logic [3:0] S_ADV_SUB  = 4'd6;
    localparam logic [3:0] S_ADV_POP  = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (mode)
                        MODE_INSERT:  state_next = S_ALLOC;
                        MODE_CANCEL:  state_next = S_CAN_WALK;
                        MODE_ADVANCE:
                        begin
                            cmd.code_we = 1'b1;
                            cmd.code    = ST_NONE;
                            state_next  = stat.head_nil ? S_FIN : S_ADV_SUB;
                        end
                        default:
                        begin
                            cmd.code_we = 1'b1;
                            cmd.code    = ST_NONE;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (stat.free_found)
                begin
                    cmd.alloc  = 1'b1;
                    state_next = S_INS_WALK;
                end
                else
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = ST_POOL_FULL;
                    state_next  = S_FIN;
                end
            end
            S_INS_WALK:
            begin
                if (stat.ptr_nil || stat.delta_gt)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_INS_LINK;
                end
                else
                    cmd.walk_step = 1'b1;
            end
            S_INS_LINK:
            begin
                cmd.ins_link = 1'b1;
                cmd.code_we  = 1'b1;
                cmd.code     = ST_INSERTED;
                state_next   = S_FIN;
            end
            S_CAN_WALK:
            begin
                if (stat.ptr_nil)
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else if (stat.match)
                begin
                    cmd.can_unlink = 1'b1;
                    state_next     = S_CAN_SUM;
                end
                else
                    cmd.can_step = 1'b1;
            end
            S_CAN_SUM:
            begin
                cmd.can_sum = 1'b1;
                cmd.code_we = 1'b1;
                cmd.code    = ST_CANCELLED;
                state_next  = S_FIN;
            end
            S_ADV_SUB:
            begin
                cmd.adv_sub = 1'b1;
                state_next  = S_ADV_POP;
            end
            S_ADV_POP:
            begin
                if (!stat.n_full && !stat.ptr_nil && stat.delta_zero)
                    cmd.adv_pop = 1'b1;
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.ptr_head = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_last)
                    state_next = S_IDLE;
                else
                    cmd.emit_next = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    `ASSERT_IMPLIES(a_emit_busy, clk, rst_n, cmd.emit, busy)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_ALWAYS(a_one_write, clk, rst_n, $onehot0({cmd.ins_place, cmd.ins_link, cmd.can_sum, cmd.adv_sub}))
endmodule

// ===== rtl/delta_list_timeout_queue_unit.sv =====
// top level of the delta list timeout queue
//
// A transaction is taken when start is high and busy is low; busy stays high
// until the last result has been shown. Results appear one per cycle with
// strobe high, the final one marked by last, and cannot be held off. An
// insert or cancel walks the linked entries one per cycle and shows one
// result; an advance pops the expired entries in turn and shows one result
// per expiry, or a single result when none expire. The single read port of
// the entry pool limits each walk to one entry at a time.
module delta_list_timeout_queue_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] delay_ms,
    input  logic [7:0]  handler_id,
    input  logic [15:0] arg_id,
    input  logic [31:0] elapsed_ms,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [7:0]  expired_handler,
    output logic [15:0] expired_arg,
    output logic [31:0] head_remaining,
    output logic        last
);
    import dltq_pkg::*;

    dltq_cmd_t  cmd;
    dltq_stat_t stat;

    // controller
    dltq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath
    dltq_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .delay_ms        (delay_ms),
        .handler_id      (handler_id),
        .arg_id          (arg_id),
        .elapsed_ms      (elapsed_ms),
        .strobe          (strobe),
        .status          (status),
        .expired_handler (expired_handler),
        .expired_arg     (expired_arg),
        .head_remaining  (head_remaining),
        .last            (last)
    );
endmodule
